/* hw/rtl/pcs_pkg.sv */
`timescale 1ns / 1ps
package pcs_pkg;

   localparam int CNT_W  = 23;
   localparam int CLIP_W = 13;
   localparam int THR_W  = CNT_W + CLIP_W;
   localparam int PROD_W = CNT_W + 14;
   localparam int NCH    = 3;

   localparam logic [CNT_W-1:0]  MAX_PIXELS = 23'd4194304;
   localparam logic [CLIP_W-1:0] CLIP_RESET = 13'd50;
   localparam logic [13:0]       SCALE      = 14'd10000;

   localparam logic OP_HIST     = 1'b0;
   localparam logic OP_MAP      = 1'b1;
   localparam logic KIND_PIXEL  = 1'b0;
   localparam logic KIND_REPORT = 1'b1;

   typedef enum logic [10:0] {
      ST_IDLE  = 11'b000_0000_0001,
      ST_HRD   = 11'b000_0000_0010,
      ST_HWR   = 11'b000_0000_0100,
      ST_THR   = 11'b000_0000_1000,
      ST_SRCH  = 11'b000_0001_0000,
      ST_DRAIN = 11'b000_0010_0000,
      ST_LIMS  = 11'b000_0100_0000,
      ST_CLR   = 11'b000_1000_0000,
      ST_MLD   = 11'b001_0000_0000,
      ST_MDIV  = 11'b010_0000_0000,
      ST_MFIN  = 11'b100_0000_0000
   } state_type;

   typedef struct packed {
      logic accept;
      logic hist_read;
      logic hist_write;
      logic start_search;
      logic search_issue;
      logic load_limits;
      logic clear_issue;
      logic map_load;
      logic div_step;
      logic map_finish;
   } cmd_type;

   typedef struct packed {
      logic pipe_empty;
      logic cnt_last;
      logic div_last;
      logic out_valid;
      logic final_flag;
   } status_type;

endpackage

/* hw/rtl/pcs_hist_ram.sv */
`timescale 1ns / 1ps
module pcs_hist_ram
   import pcs_pkg::*;
(
   input  logic             clock,
   input  logic             we,
   input  logic [7:0]       waddr,
   input  logic [CNT_W-1:0] wdata,
   input  logic [7:0]       raddr_a,
   input  logic [7:0]       raddr_b,
   output logic [CNT_W-1:0] rdata_a,
   output logic [CNT_W-1:0] rdata_b
);

   logic [CNT_W-1:0] mem [256];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
   end

endmodule

/* hw/rtl/pcs_ctrl.sv */
`timescale 1ns / 1ps
module pcs_ctrl
   import pcs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_operation,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   assign req_ready = (state_ff == ST_IDLE) && !status.out_valid;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               cmd.accept = 1'b1;
               state_in   = (req_operation == OP_MAP) ? ST_MLD : ST_HRD;
            end
         end
         ST_HRD: begin
            cmd.hist_read = 1'b1;
            state_in      = ST_HWR;
         end
         ST_HWR: begin
            cmd.hist_write = 1'b1;
            state_in       = status.final_flag ? ST_THR : ST_IDLE;
         end
         ST_THR: begin
            cmd.start_search = 1'b1;
            state_in         = ST_SRCH;
         end
         ST_SRCH: begin
            cmd.search_issue = 1'b1;
            if (status.cnt_last) state_in = ST_DRAIN;
         end
         ST_DRAIN: begin
            if (status.pipe_empty) state_in = ST_LIMS;
         end
         ST_LIMS: begin
            cmd.load_limits = 1'b1;
            state_in        = ST_CLR;
         end
         ST_CLR: begin
            cmd.clear_issue = 1'b1;
            if (status.cnt_last) state_in = ST_IDLE;
         end
         ST_MLD: begin
            cmd.map_load = 1'b1;
            state_in     = ST_MDIV;
         end
         ST_MDIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) state_in = ST_MFIN;
         end
         ST_MFIN: begin
            cmd.map_finish = 1'b1;
            state_in       = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // reset lands in the clearing sweep so the histograms start at zero
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLR;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

/* hw/rtl/pcs_dp.sv */
`timescale 1ns / 1ps
module pcs_dp
   import pcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   output status_type        status,
   input  logic [7:0]        req_blue_in,
   input  logic [7:0]        req_green_in,
   input  logic [7:0]        req_red_in,
   input  logic              req_final_pixel,
   input  logic              csr_wr_en,
   input  logic [CLIP_W-1:0] csr_wr_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_blue_out,
   output logic [7:0]        rsp_green_out,
   output logic [7:0]        rsp_red_out,
   output logic [7:0]        rsp_blue_low,
   output logic [7:0]        rsp_blue_high,
   output logic [7:0]        rsp_green_low,
   output logic [7:0]        rsp_green_high,
   output logic [7:0]        rsp_red_low,
   output logic [7:0]        rsp_red_high,
   output logic              rsp_overflowed
);

   logic [CLIP_W-1:0] clip_ff;
   logic [7:0]        pix_ff [NCH];
   logic              fin_ff;
   logic [CNT_W-1:0]  pc_ff;
   logic              ovf_ff;
   logic              full;
   logic [7:0]        cnt_ff;
   logic [THR_W-1:0]  thr_ff;

   logic [CNT_W-1:0]  rd_a [NCH];
   logic [CNT_W-1:0]  rd_b [NCH];

   // search pipeline: read, accumulate, scale, compare
   logic              v1_ff, v2_ff, v3_ff;
   logic [7:0]        idx1_ff, idx2_ff, idx3_ff;
   logic [CNT_W-1:0]  sum_lo_ff [NCH];
   logic [CNT_W-1:0]  sum_hi_ff [NCH];
   logic [PROD_W-1:0] prod_lo_ff [NCH];
   logic [PROD_W-1:0] prod_hi_ff [NCH];
   logic              fnd_lo_ff [NCH];
   logic              fnd_hi_ff [NCH];
   logic [7:0]        cand_lo_ff [NCH];
   logic [7:0]        cand_hi_ff [NCH];

   logic [7:0]        lim_lo_ff [NCH];
   logic [7:0]        lim_hi_ff [NCH];
   logic [7:0]        new_lo [NCH];
   logic [7:0]        new_hi [NCH];

   // mapping divider, one quotient bit per cycle
   logic [2:0]        div_cnt_ff;
   logic [7:0]        rem_ff [NCH];
   logic [7:0]        nlo_ff [NCH];
   logic [7:0]        q_ff [NCH];
   logic [7:0]        d_ff [NCH];
   logic              sat0_ff [NCH];
   logic              sat1_ff [NCH];
   logic [7:0]        mapped [NCH];

   logic              out_valid_ff;
   logic              kind_ff;
   logic [7:0]        val_ff [NCH];
   logic [7:0]        olo_ff [NCH];
   logic [7:0]        ohi_ff [NCH];
   logic              oovf_ff;

   assign full = (pc_ff == MAX_PIXELS);

   for (genvar c = 0; c < NCH; c++) begin : g_ram
      pcs_hist_ram u_ram (
         .clock   (clock),
         .we      ((cmd.hist_write && !full) || cmd.clear_issue),
         .waddr   (cmd.clear_issue ? cnt_ff : pix_ff[c]),
         .wdata   (cmd.clear_issue ? '0 : rd_a[c] + 1'b1),
         .raddr_a (cmd.hist_read ? pix_ff[c] : cnt_ff),
         .raddr_b (~cnt_ff),
         .rdata_a (rd_a[c]),
         .rdata_b (rd_b[c])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clip_ff <= CLIP_RESET;
      end else if (csr_wr_en) begin
         clip_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         pix_ff[0] <= req_blue_in;
         pix_ff[1] <= req_green_in;
         pix_ff[2] <= req_red_in;
         fin_ff    <= req_final_pixel;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff  <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.load_limits) begin
         pc_ff  <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.hist_write) begin
         if (full) ovf_ff <= 1'b1;
         else      pc_ff  <= pc_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else if (cmd.start_search || cmd.load_limits) begin
         cnt_ff <= '0;
      end else if (cmd.search_issue || cmd.clear_issue) begin
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.start_search) begin
         thr_ff <= pc_ff * clip_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.search_issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      idx1_ff <= cnt_ff;
      idx2_ff <= idx1_ff;
      idx3_ff <= idx2_ff;
      for (int c = 0; c < NCH; c++) begin
         if (cmd.start_search) begin
            sum_lo_ff[c]  <= '0;
            sum_hi_ff[c]  <= '0;
            fnd_lo_ff[c]  <= 1'b0;
            fnd_hi_ff[c]  <= 1'b0;
            cand_lo_ff[c] <= 8'd0;
            cand_hi_ff[c] <= 8'd255;
         end else begin
            if (v1_ff) begin
               sum_lo_ff[c] <= sum_lo_ff[c] + rd_a[c];
               sum_hi_ff[c] <= sum_hi_ff[c] + rd_b[c];
            end
            if (v3_ff && !fnd_lo_ff[c] && (prod_lo_ff[c] > PROD_W'(thr_ff))) begin
               fnd_lo_ff[c]  <= 1'b1;
               cand_lo_ff[c] <= idx3_ff;
            end
            if (v3_ff && !fnd_hi_ff[c] && (prod_hi_ff[c] > PROD_W'(thr_ff))) begin
               fnd_hi_ff[c]  <= 1'b1;
               cand_hi_ff[c] <= ~idx3_ff;
            end
         end
         prod_lo_ff[c] <= sum_lo_ff[c] * SCALE;
         prod_hi_ff[c] <= sum_hi_ff[c] * SCALE;
      end
   end

   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         if (cand_hi_ff[c] <= cand_lo_ff[c]) begin
            new_lo[c] = 8'd0;
            new_hi[c] = 8'd255;
         end else begin
            new_lo[c] = cand_lo_ff[c];
            new_hi[c] = cand_hi_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NCH; c++) begin
            lim_lo_ff[c] <= 8'd0;
            lim_hi_ff[c] <= 8'd255;
         end
      end else if (cmd.load_limits) begin
         for (int c = 0; c < NCH; c++) begin
            lim_lo_ff[c] <= new_lo[c];
            lim_hi_ff[c] <= new_hi[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= '0;
      end else if (cmd.map_load) begin
         div_cnt_ff <= '0;
      end else if (cmd.div_step) begin
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      for (int c = 0; c < NCH; c++) begin
         logic [7:0]  dif;
         logic [15:0] num;
         logic [8:0]  trial;
         dif   = pix_ff[c] - lim_lo_ff[c];
         num   = {dif, 8'd0} - {8'd0, dif};
         trial = {rem_ff[c], nlo_ff[c][7]};
         if (cmd.map_load) begin
            // quotient stays below 255, so the top byte is already a remainder
            rem_ff[c]  <= num[15:8];
            nlo_ff[c]  <= num[7:0];
            q_ff[c]    <= '0;
            d_ff[c]    <= lim_hi_ff[c] - lim_lo_ff[c];
            sat0_ff[c] <= pix_ff[c] <= lim_lo_ff[c];
            sat1_ff[c] <= pix_ff[c] >= lim_hi_ff[c];
         end else if (cmd.div_step) begin
            nlo_ff[c] <= {nlo_ff[c][6:0], 1'b0};
            if (trial >= {1'b0, d_ff[c]}) begin
               rem_ff[c] <= 8'(trial - {1'b0, d_ff[c]});
               q_ff[c]   <= {q_ff[c][6:0], 1'b1};
            end else begin
               rem_ff[c] <= trial[7:0];
               q_ff[c]   <= {q_ff[c][6:0], 1'b0};
            end
         end
      end
   end

   // round half to even, then saturate
   always_comb begin
      for (int c = 0; c < NCH; c++) begin
         logic [8:0] twice;
         logic       up;
         twice = {rem_ff[c], 1'b0};
         up    = (twice > {1'b0, d_ff[c]}) ||
                 ((twice == {1'b0, d_ff[c]}) && q_ff[c][0]);
         if (sat0_ff[c])                  mapped[c] = 8'd0;
         else if (sat1_ff[c])             mapped[c] = 8'd255;
         else if (q_ff[c] == 8'd255)      mapped[c] = 8'd255;
         else                             mapped[c] = q_ff[c] + {7'd0, up};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.load_limits || cmd.map_finish) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_limits) begin
         kind_ff <= KIND_REPORT;
         oovf_ff <= ovf_ff;
         for (int c = 0; c < NCH; c++) begin
            val_ff[c] <= 8'd0;
            olo_ff[c] <= new_lo[c];
            ohi_ff[c] <= new_hi[c];
         end
      end else if (cmd.map_finish) begin
         kind_ff <= KIND_PIXEL;
         oovf_ff <= ovf_ff;
         for (int c = 0; c < NCH; c++) begin
            val_ff[c] <= mapped[c];
            olo_ff[c] <= lim_lo_ff[c];
            ohi_ff[c] <= lim_hi_ff[c];
         end
      end
   end

   assign status.pipe_empty = !v1_ff && !v2_ff && !v3_ff;
   assign status.cnt_last   = (cnt_ff == 8'd255);
   assign status.div_last   = (div_cnt_ff == 3'd7);
   assign status.out_valid  = out_valid_ff;
   assign status.final_flag = fin_ff;

   assign rsp_valid      = out_valid_ff;
   assign rsp_kind       = kind_ff;
   assign rsp_blue_out   = val_ff[0];
   assign rsp_green_out  = val_ff[1];
   assign rsp_red_out    = val_ff[2];
   assign rsp_blue_low   = olo_ff[0];
   assign rsp_blue_high  = ohi_ff[0];
   assign rsp_green_low  = olo_ff[1];
   assign rsp_green_high = ohi_ff[1];
   assign rsp_red_low    = olo_ff[2];
   assign rsp_red_high   = ohi_ff[2];
   assign rsp_overflowed = oovf_ff;

endmodule

/* hw/rtl/percentile_contrast_stretch.sv */
// Per-channel percentile stretch of 8-bit blue/green/red pixels.
// req_* carries one pixel item: operation 0 adds it to the three histograms,
// operation 1 maps it through the current limits. final_pixel on a histogram
// item ends the pass: limits are searched, reported (rsp_kind = 1) and the
// histograms are cleared. csr_wr_en/csr_wr_data set the clip amount.
// Items are taken one at a time; req_ready is high only when the block is
// idle and the output register is empty.
// Work per item:
//   histogram item  read-modify-write of the bin memories
//   map item        load, a bit-serial divider per channel, result
//   final item      256-bin search walking both ends at once
//                   through two read ports, pipeline drain, bin clear
// Map and report results appear in the output register and stay there until
// rsp_ready; while they wait no new item is accepted.
// After reset the block clears the bin memories before req_ready rises;
// the clip register returns to 50.
`timescale 1ns / 1ps
module percentile_contrast_stretch
   import pcs_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_operation,
   input  logic [7:0]        req_blue_in,
   input  logic [7:0]        req_green_in,
   input  logic [7:0]        req_red_in,
   input  logic              req_final_pixel,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_kind,
   output logic [7:0]        rsp_blue_out,
   output logic [7:0]        rsp_green_out,
   output logic [7:0]        rsp_red_out,
   output logic [7:0]        rsp_blue_low,
   output logic [7:0]        rsp_blue_high,
   output logic [7:0]        rsp_green_low,
   output logic [7:0]        rsp_green_high,
   output logic [7:0]        rsp_red_low,
   output logic [7:0]        rsp_red_high,
   output logic              rsp_overflowed,
   input  logic              csr_wr_en,
   input  logic [CLIP_W-1:0] csr_wr_data
);

   cmd_type    cmd;
   status_type status;

   pcs_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_ready     (req_ready),
      .status        (status),
      .cmd           (cmd)
   );

   pcs_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .req_blue_in     (req_blue_in),
      .req_green_in    (req_green_in),
      .req_red_in      (req_red_in),
      .req_final_pixel (req_final_pixel),
      .csr_wr_en       (csr_wr_en),
      .csr_wr_data     (csr_wr_data),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_kind        (rsp_kind),
      .rsp_blue_out    (rsp_blue_out),
      .rsp_green_out   (rsp_green_out),
      .rsp_red_out     (rsp_red_out),
      .rsp_blue_low    (rsp_blue_low),
      .rsp_blue_high   (rsp_blue_high),
      .rsp_green_low   (rsp_green_low),
      .rsp_green_high  (rsp_green_high),
      .rsp_red_low     (rsp_red_low),
      .rsp_red_high    (rsp_red_high),
      .rsp_overflowed  (rsp_overflowed)
   );

endmodule

/* hw/rtl/pcs_checker.sv */
`timescale 1ns / 1ps
module pcs_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic       rsp_kind,
   input logic [7:0] rsp_blue_out,
   input logic [7:0] rsp_green_out,
   input logic [7:0] rsp_red_out,
   input logic [7:0] rsp_blue_low,
   input logic [7:0] rsp_blue_high,
   input logic [7:0] rsp_green_low,
   input logic [7:0] rsp_green_high,
   input logic [7:0] rsp_red_low,
   input logic [7:0] rsp_red_high
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second item taken while busy");

   a_report_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind |->
         rsp_blue_out == 8'd0 && rsp_green_out == 8'd0 && rsp_red_out == 8'd0)
      else $error("report carries pixel values");

   a_limits_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
         rsp_blue_high > rsp_blue_low && rsp_green_high > rsp_green_low &&
         rsp_red_high > rsp_red_low)
      else $error("limit pair not ordered");

endmodule

bind percentile_contrast_stretch pcs_checker u_pcs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_kind       (rsp_kind),
   .rsp_blue_out   (rsp_blue_out),
   .rsp_green_out  (rsp_green_out),
   .rsp_red_out    (rsp_red_out),
   .rsp_blue_low   (rsp_blue_low),
   .rsp_blue_high  (rsp_blue_high),
   .rsp_green_low  (rsp_green_low),
   .rsp_green_high (rsp_green_high),
   .rsp_red_low    (rsp_red_low),
   .rsp_red_high   (rsp_red_high)
);
